>>> rtl/zero_crossing_segmenter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the zero crossing segmenter
// Shorthand for clocked implication checks, gated off while reset is held.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_SEGMENTER_TOP_MACROS_SVH
`define ZERO_CROSSING_SEGMENTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZCS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zcs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ZCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zcs: next-cycle check failed");

`endif

>>> rtl/zcs_pkg.sv
// ----------------------------------------------------------------------------
// Zero crossing segmenter package
// Widths, shared types and tuser bit positions for the segmenter.
// ----------------------------------------------------------------------------
package zcs_pkg;

  localparam int TIME_BITS  = 44;
  localparam int VALUE_BITS = 32;

  // Sum of two value magnitudes needs one bit more than a value.
  localparam int SUM_BITS  = VALUE_BITS + 1;
  localparam int PROD_BITS = TIME_BITS + VALUE_BITS;

  // The shared adder covers the multiply accumulate, the trial subtract and
  // the final offset of the crossing time.
  localparam int ALU_BITS = (TIME_BITS + 1 > VALUE_BITS + 2) ? TIME_BITS + 1 : VALUE_BITS + 2;

  localparam int STEP_MAX = (TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS;
  localparam int CNT_BITS = $clog2(STEP_MAX);

  localparam int IN_DATA_BITS  = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_USER_BITS = 3;

  localparam int USER_POSITIVE = 0;
  localparam int USER_START    = 1;
  localparam int USER_END      = 2;

  typedef logic [TIME_BITS-1:0]         time_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS-1:0]        mag_t;
  typedef logic [SUM_BITS-1:0]          sum_t;
  typedef logic [ALU_BITS-1:0]          alu_t;

  typedef struct packed {
    alu_t a;
    alu_t b;
    logic sub;
  } alu_req_t;

  typedef struct packed {
    time_t  time_stamp;
    value_t sample_value;
    logic   curve_start;
    logic   curve_end;
  } point_t;

  typedef struct packed {
    time_t  out_time;
    value_t out_value;
    logic   run_positive;
    logic   run_start;
    logic   run_end;
    logic   last;
  } result_t;

endpackage

>>> rtl/zero_crossing_segmenter_top.sv
// ----------------------------------------------------------------------------
// Zero crossing segmenter, top level
// A point with no sign change passes through the prepare and emit states only.
// A sign change adds the shift-add multiply and the restoring divide on one
// shared adder, and emits the crossing end and start before the point itself.
// Output stalls hold the core in its emit state. Reset is asynchronous and
// active low: previous point zero, sign positive.
// ----------------------------------------------------------------------------
module zero_crossing_segmenter_top import zcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata: time_stamp, sample_value, then zero padding
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // tuser: curve_start
  input  logic                     s_axis_tuser_i,
  input  logic                     s_axis_tlast_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // tdata: out_time, out_value, then zero padding
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,
  // tuser: run_positive, run_start, run_end
  output logic [OUT_USER_BITS-1:0] m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);

  // Each accepted request carries one curve point. The core works on one
  // point at a time and hands its results over one by one; the output
  // register here lets the core return to idle and take the next request
  // while the final result still waits on the downstream side.

  point_t  in_point;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  logic    out_valid_q;
  result_t out_res_q;

  assign in_point.time_stamp   = s_axis_tdata_i[TIME_BITS-1:0];
  assign in_point.sample_value = s_axis_tdata_i[TIME_BITS +: VALUE_BITS];
  assign in_point.curve_start  = s_axis_tuser_i;
  assign in_point.curve_end    = s_axis_tlast_i;

  zcs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_point_i  (in_point),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The output register can take a new result when it is empty or when its
  // current result leaves in the same cycle.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_BITS'({out_res_q.out_value, out_res_q.out_time});
  assign m_axis_tlast_o  = out_res_q.last;

  always_comb begin
    m_axis_tuser_o                = '0;
    m_axis_tuser_o[USER_POSITIVE] = out_res_q.run_positive;
    m_axis_tuser_o[USER_START]    = out_res_q.run_start;
    m_axis_tuser_o[USER_END]      = out_res_q.run_end;
  end

endmodule

>>> rtl/zcs_addsub.sv
// ----------------------------------------------------------------------------
// Shared adder/subtractor
// One carry chain serving the multiply, divide and final offset steps of the sequencer.
// ----------------------------------------------------------------------------
module zcs_addsub import zcs_pkg::*; (
  input  alu_req_t          req_i,
  output logic [ALU_BITS:0] sum_o
);

  alu_t b_eff;

  // Subtraction as a + ~b + 1; the top bit is then the no-borrow flag.
  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_o = {1'b0, req_i.a} + {1'b0, b_eff} + {{ALU_BITS{1'b0}}, req_i.sub};

endmodule

>>> rtl/zcs_core.sv
// ----------------------------------------------------------------------------
// Segmenter sequencer
// Sign tracking, shift-add multiply, restoring divide and result emission.
// ----------------------------------------------------------------------------
`include "zero_crossing_segmenter_top_macros.svh"

module zcs_core import zcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  point_t  in_point_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [1:0] RES_OLD_END   = 2'd0;
  localparam logic [1:0] RES_NEW_START = 2'd1;
  localparam logic [1:0] RES_POINT     = 2'd2;

  logic [2:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [1:0]          idx_q, idx_d;

  time_t  prev_time_q;
  value_t prev_value_q;
  logic   sign_q;

  point_t pt_q;
  time_t  base_q;
  time_t  dmag_q;
  logic   back_q;
  sum_t   smag_q;
  time_t  prod_hi_q;
  mag_t   prod_lo_q;
  sum_t   rem_q;
  time_t  quo_q;
  time_t  cx_q;

  logic                   pos;
  logic                   crossing;
  mag_t                   pmag;
  mag_t                   vmag;
  logic                   back;
  time_t                  dmag;
  sum_t                   smag;
  logic [PROD_BITS-1:0]   prod;
  logic [SUM_BITS:0]      rem_shift;
  logic                   no_borrow;
  alu_req_t               alu_req;
  logic [ALU_BITS:0]      alu_sum;

  zcs_addsub u_addsub (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  // Sign and magnitudes of the point under work against the stored one.
  assign pos      = ~pt_q.sample_value[VALUE_BITS-1];
  assign crossing = ~pt_q.curve_start && (pos != sign_q);
  assign pmag  = prev_value_q[VALUE_BITS-1] ? mag_t'(~prev_value_q) + mag_t'(1)
                                            : mag_t'(prev_value_q);
  assign vmag  = pt_q.sample_value[VALUE_BITS-1] ? mag_t'(~pt_q.sample_value) + mag_t'(1)
                                                 : mag_t'(pt_q.sample_value);
  assign back  = pt_q.time_stamp < prev_time_q;
  assign dmag  = back ? prev_time_q - pt_q.time_stamp : pt_q.time_stamp - prev_time_q;
  assign smag  = sum_t'(pmag) + sum_t'(vmag);

  assign prod      = {prod_hi_q, prod_lo_q};
  assign rem_shift = {rem_q, quo_q[TIME_BITS-1]};
  assign no_borrow = alu_sum[ALU_BITS];

  always_comb begin
    alu_req = '0;
    case (state_q)
      S_MUL: begin
        alu_req.a = alu_t'(prod_hi_q);
        alu_req.b = prod_lo_q[0] ? alu_t'(dmag_q) : '0;
      end
      S_DIV: begin
        alu_req.a   = alu_t'(rem_shift);
        alu_req.b   = alu_t'(smag_q);
        alu_req.sub = 1'b1;
      end
      S_FIN: begin
        alu_req.a   = alu_t'(base_q);
        alu_req.b   = alu_t'(quo_q);
        alu_req.sub = back_q;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cnt_d = '0;
        if (crossing) begin
          state_d = S_MUL;
        end else begin
          idx_d   = RES_POINT;
          state_d = S_EMIT;
        end
      end
      S_MUL: begin
        if (cnt_q == CNT_BITS'(VALUE_BITS - 1)) begin
          state_d = S_LOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LOAD: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == CNT_BITS'(TIME_BITS - 1)) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        idx_d   = RES_OLD_END;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready_i) begin
          if (idx_q == RES_POINT) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      idx_q        <= RES_POINT;
      prev_time_q  <= '0;
      prev_value_q <= '0;
      sign_q       <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (state_q == S_PREP) begin
        prev_time_q  <= pt_q.time_stamp;
        prev_value_q <= pt_q.sample_value;
        sign_q       <= pos;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pt_q <= in_point_i;
        end
      end
      S_PREP: begin
        base_q    <= prev_time_q;
        dmag_q    <= dmag;
        back_q    <= back;
        smag_q    <= smag;
        prod_hi_q <= '0;
        prod_lo_q <= pmag;
      end
      S_MUL: begin
        prod_hi_q <= alu_sum[TIME_BITS:1];
        prod_lo_q <= {alu_sum[0], prod_lo_q[VALUE_BITS-1:1]};
      end
      S_LOAD: begin
        // Leading quotient bits are zero, so the top of the product seeds the
        // remainder and only the low bits are shifted through the divider.
        rem_q <= sum_t'(prod[PROD_BITS-1 -: VALUE_BITS]);
        quo_q <= prod[TIME_BITS-1:0];
      end
      S_DIV: begin
        rem_q <= no_borrow ? alu_sum[SUM_BITS-1:0] : rem_shift[SUM_BITS-1:0];
        quo_q <= {quo_q[TIME_BITS-2:0], no_borrow};
      end
      S_FIN: begin
        cx_q <= alu_sum[TIME_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);

  always_comb begin
    res_o = '0;
    case (idx_q)
      RES_OLD_END: begin
        res_o.out_time     = cx_q;
        res_o.run_positive = ~pos;
        res_o.run_end      = 1'b1;
      end
      RES_NEW_START: begin
        res_o.out_time     = cx_q;
        res_o.run_positive = pos;
        res_o.run_start    = 1'b1;
      end
      default: begin
        res_o.out_time     = pt_q.time_stamp;
        res_o.out_value    = pt_q.sample_value;
        res_o.run_positive = pos;
        res_o.run_start    = pt_q.curve_start;
        res_o.run_end      = pt_q.curve_end;
        res_o.last         = 1'b1;
      end
    endcase
  end

  `ZCS_ASSERT_IMPLIES(a_rem_below_divisor, state_q == S_DIV, rem_q < smag_q)
  `ZCS_ASSERT_IMPLIES(a_quotient_in_span, state_q == S_FIN, quo_q <= dmag_q)
  `ZCS_ASSERT_NEXT(a_accept_to_prep, in_valid_i && in_ready_o, state_q == S_PREP)
  `ZCS_ASSERT_IMPLIES(a_crossing_shape, res_valid_o && !res_o.last, (res_o.out_value == '0) && (res_o.run_start != res_o.run_end))

endmodule
